// ----- sv/selective_repeat_reorder_window_assert.svh -----
// Assertion macros for the selective-repeat reorder window.
// Included by the RTL files that carry concurrent checks; relies on clk and rst in scope.
`ifndef SELECTIVE_REPEAT_REORDER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_REORDER_WINDOW_ASSERT_SVH
`ifndef SYNTH
`define SRRW_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("srrw: same-cycle check failed");
`define SRRW_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("srrw: next-cycle check failed");
`else
`define SRRW_ASSERT_NOW(label, cond, prop)
`define SRRW_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ----- sv/srrw_pkg.sv -----
// Shared types and constants for the selective-repeat reorder window.
// No dependencies; imported by the top level.
`default_nettype none
package srrw_pkg;

  localparam int SEQ_W            = 20;
  localparam int SLOT_IDX_W       = 3;
  localparam int DEF_WINDOW_SLOTS = 8;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;

  localparam logic [SEQ_W-1:0] SEQ_RESET = SEQ_W'(1);

  // register select bit of paddr
  localparam logic REG_TOTAL_PACKETS = 1'b0;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic [1:0] {
    ACT_ACK     = 2'd0,
    ACT_DELIVER = 2'd1,
    ACT_DRAIN   = 2'd2,
    ACT_STORE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELIV,
    S_RD,
    S_CMP,
    S_STORE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic kind;
    seq_t seq_num;
    logic crc_ok;
  } pkt_t;

  typedef struct packed {
    action_t               action;
    seq_t                  out_seq;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  last;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/srrw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the window slot sequence numbers.
`default_nettype none
module srrw_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/selective_repeat_reorder_window.sv -----
// Selective-repeat receive window: one slot-compare unit driven by a sequencer.
// Order: the expected or an older packet is acked before any slot scan; a newer packet
// scans all N slots, through S_RD and S_CMP per slot, before it is acked; each drained
// slot restarts the scan at slot 0.
// Throughput: one packet at a time; pkt_stall is high while a packet is in work.
// Reset: synchronous; clears expected number to 1, all slot valid bits and the total reg.
`default_nettype none
`include "selective_repeat_reorder_window_assert.svh"
module selective_repeat_reorder_window #(
  parameter int WINDOW_SLOTS = srrw_pkg::DEF_WINDOW_SLOTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pkt_valid,
  output logic                                 pkt_stall,
  input  wire srrw_pkg::pkt_t                  pkt,
  output logic                                 res_valid,
  input  wire logic                            res_stall,
  output srrw_pkg::res_t                       res,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [srrw_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [srrw_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [srrw_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import srrw_pkg::*;

  localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SLOTS - 1);

  state_t                  state, state_next;
  seq_t                    total_packets;
  seq_t                    expected_seq, expected_seq_next;
  seq_t                    cur_seq, cur_seq_next;
  logic                    drain, drain_next;
  logic [IDX_W-1:0]        idx, idx_next;
  logic                    held, held_next;
  logic                    free_found, free_found_next;
  logic [IDX_W-1:0]        free_idx, free_idx_next;
  logic [WINDOW_SLOTS-1:0] slot_valid, slot_valid_next;
  action_t                 pend_action, pend_action_next;
  seq_t                    pend_seq, pend_seq_next;
  logic [SLOT_IDX_W-1:0]   pend_slot, pend_slot_next;

  logic accept, pkt_good, push_ok, push, push_last, hit, ram_we, cfg_wr;
  seq_t key, ram_rdata;

  srrw_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (WINDOW_SLOTS),
    .AW    (IDX_W)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (cur_seq),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_TOTAL_PACKETS) ?
                  APB_DATA_W'(total_packets) : '0;

  assign pkt_stall = (state != S_IDLE);
  assign accept    = pkt_valid && !pkt_stall;
  assign pkt_good  = (pkt.kind == KIND_DATA) && pkt.crc_ok && !(pkt.seq_num > total_packets);
  assign push_ok   = !res_valid || !res_stall;
  assign key       = drain ? expected_seq : cur_seq;
  assign hit       = slot_valid[idx] && (ram_rdata == key);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && pkt_good) begin
          if (pkt.seq_num == expected_seq) begin
            state_next = S_DELIV;
          end else if (pkt.seq_num > expected_seq) begin
            state_next = S_RD;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_DELIV: begin
        if (push_ok) begin
          state_next = S_RD;
        end
      end
      S_RD: state_next = S_CMP;
      S_CMP: begin
        if (drain && hit) begin
          state_next = push_ok ? S_RD : S_CMP;
        end else if (idx == LAST_IDX) begin
          state_next = drain ? S_FIN : S_STORE;
        end else begin
          state_next = S_RD;
        end
      end
      S_STORE: begin
        if (held || !free_found || push_ok) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (push_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    expected_seq_next = expected_seq;
    cur_seq_next      = cur_seq;
    drain_next        = drain;
    idx_next          = idx;
    held_next         = held;
    free_found_next   = free_found;
    free_idx_next     = free_idx;
    slot_valid_next   = slot_valid;
    pend_action_next  = pend_action;
    pend_seq_next     = pend_seq;
    pend_slot_next    = pend_slot;
    push              = 1'b0;
    push_last         = 1'b0;
    ram_we            = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (pkt.kind == KIND_RESTART) begin
            expected_seq_next = SEQ_RESET;
            slot_valid_next   = '0;
          end else if (pkt_good) begin
            cur_seq_next     = pkt.seq_num;
            pend_action_next = ACT_ACK;
            pend_seq_next    = pkt.seq_num;
            pend_slot_next   = '0;
            idx_next         = '0;
            held_next        = 1'b0;
            free_found_next  = 1'b0;
            drain_next       = (pkt.seq_num == expected_seq);
          end
        end
      end
      S_DELIV: begin
        if (push_ok) begin
          push              = 1'b1;
          pend_action_next  = ACT_DELIVER;
          pend_seq_next     = cur_seq;
          pend_slot_next    = '0;
          expected_seq_next = expected_seq + 1'b1;
        end
      end
      S_CMP: begin
        if (drain) begin
          if (hit) begin
            if (push_ok) begin
              push                 = 1'b1;
              pend_action_next     = ACT_DRAIN;
              pend_seq_next        = expected_seq;
              pend_slot_next       = SLOT_IDX_W'(idx);
              slot_valid_next[idx] = 1'b0;
              expected_seq_next    = expected_seq + 1'b1;
              idx_next             = '0;
            end
          end else if (idx != LAST_IDX) begin
            idx_next = idx + 1'b1;
          end
        end else begin
          if (hit) begin
            held_next = 1'b1;
          end
          if (!slot_valid[idx] && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = idx;
          end
          if (idx != LAST_IDX) begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_STORE: begin
        if (!held && free_found && push_ok) begin
          push                      = 1'b1;
          ram_we                    = 1'b1;
          pend_action_next          = ACT_STORE;
          pend_seq_next             = cur_seq;
          pend_slot_next            = SLOT_IDX_W'(free_idx);
          slot_valid_next[free_idx] = 1'b1;
        end
      end
      S_FIN: begin
        if (push_ok) begin
          push      = 1'b1;
          push_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      total_packets <= '0;
      expected_seq  <= SEQ_RESET;
      slot_valid    <= '0;
      res_valid     <= 1'b0;
    end else begin
      state        <= state_next;
      expected_seq <= expected_seq_next;
      slot_valid   <= slot_valid_next;
      if (cfg_wr && (paddr[APB_ADDR_W-1] == REG_TOTAL_PACKETS)) begin
        total_packets <= pwdata[SEQ_W-1:0];
      end
      if (push) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_seq     <= cur_seq_next;
    drain       <= drain_next;
    idx         <= idx_next;
    held        <= held_next;
    free_found  <= free_found_next;
    free_idx    <= free_idx_next;
    pend_action <= pend_action_next;
    pend_seq    <= pend_seq_next;
    pend_slot   <= pend_slot_next;
    if (push) begin
      res.action     <= pend_action;
      res.out_seq    <= pend_seq;
      res.slot_index <= pend_slot;
      res.last       <= push_last;
    end
  end

  `SRRW_ASSERT_NEXT(a_fin_to_idle, (state == S_FIN) && push_ok, state == S_IDLE)
  `SRRW_ASSERT_NEXT(a_store_marks, ram_we, slot_valid[free_idx])
  `SRRW_ASSERT_NEXT(a_drain_adv, (state == S_CMP) && drain && hit && push_ok,
                    expected_seq == SEQ_W'($past(expected_seq) + 1'b1))
  `SRRW_ASSERT_NOW(a_res_from_push, $rose(res_valid), $past(push))

endmodule
`default_nettype wire
